>>> hdl/lidar_sector_obstacle_avoider_core_defines.svh
// Assertion macros used by the lidar sector obstacle avoider checker file.
`ifndef LIDAR_SECTOR_OBSTACLE_AVOIDER_CORE_DEFINES_SVH
`define LIDAR_SECTOR_OBSTACLE_AVOIDER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define LSOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LSOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds after ante, as a delayed form of LSOA_ASSERT_NEXT.
`define LSOA_ASSERT_LATER3(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

>>> hdl/lsoa_pkg.sv
// Shared constants, sector lookup and noise functions of the lidar sector obstacle avoider.
`default_nettype none

package lsoa_pkg;

    // Field and bus widths
    localparam int RANGE_W   = 16;
    localparam int ANGLE_W   = 9;
    localparam int SPEED_W   = 11;
    localparam int TURN_W    = 12;
    localparam int ANGULAR_W = 13;
    localparam int LFSR_W    = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_OBSTACLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CREEP_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_FLOOR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RANGE_CEILING = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CRUISE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CREEP = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TURN = 3'd6;

    // Register reset values
    localparam logic [RANGE_W-1:0] OBSTACLE_RST = 16'd500;
    localparam logic [RANGE_W-1:0] CREEP_LIMIT_RST = 16'd300;
    localparam logic [RANGE_W-1:0] RANGE_FLOOR_RST = 16'd120;
    localparam logic [RANGE_W-1:0] RANGE_CEILING_RST = 16'd3500;
    localparam logic [SPEED_W-1:0] CRUISE_RST = 11'd300;
    localparam logic [SPEED_W-1:0] CREEP_RST = 11'd150;
    localparam logic [TURN_W-1:0]  TURN_RST = 12'd800;

    // Sector codes
    localparam int SECTOR_COUNT = 6;
    localparam int SECTOR_W = 3;
    localparam logic [SECTOR_W-1:0] SEC_FRONT = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_FLEFT = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_FRIGHT = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_LEFT = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_RIGHT = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_BACK = 3'd5;
    localparam logic [SECTOR_W-1:0] SEC_NONE = 3'd6;

    // Reading of a sector with no valid sample
    localparam logic [RANGE_W-1:0] EMPTY_MM = 16'd10000;

    // Noise generator
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [16:0] NOISE_RECIP = 17'd83887;   // ceil(2^23 / 100)
    localparam int NOISE_SHIFT = 23;
    localparam logic [9:0] NOISE_MOD = 10'd100;
    localparam logic signed [ANGULAR_W-1:0] NOISE_BIAS = 13'sd100;

    // Map a bearing to its sector
    function automatic logic [SECTOR_W-1:0] sector_of(input logic [ANGLE_W-1:0] a);
        logic [SECTOR_W-1:0] s;
        s = SEC_NONE;
        if (a inside {[9'd0:9'd15], [9'd345:9'd359]}) s = SEC_FRONT;
        else if (a inside {[9'd30:9'd60]}) s = SEC_FLEFT;
        else if (a inside {[9'd300:9'd330]}) s = SEC_FRIGHT;
        else if (a inside {[9'd80:9'd100]}) s = SEC_LEFT;
        else if (a inside {[9'd260:9'd280]}) s = SEC_RIGHT;
        else if (a inside {[9'd170:9'd190]}) s = SEC_BACK;
        return s;
    endfunction

    // Advance the Fibonacci LFSR x^16+x^14+x^13+x^11+1 by one step
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
        logic fb;
        fb = x[0] ^ x[2] ^ x[3] ^ x[5];
        return {fb, x[LFSR_W-1:1]};
    endfunction

    // Turn noise 2*((v mod 100) - 50), mod done by an exact reciprocal
    function automatic logic signed [ANGULAR_W-1:0] noise_of(input logic [LFSR_W-1:0] v);
        logic [32:0] prod;
        logic [9:0]  quo;
        logic [15:0] quo_x100;
        logic [6:0]  rem;
        prod = 33'(v) * 33'(NOISE_RECIP);
        quo = prod[32:NOISE_SHIFT];
        quo_x100 = 16'(quo) * 16'(NOISE_MOD);
        rem = 7'(v - quo_x100);
        return $signed({5'b0, rem, 1'b0}) - NOISE_BIAS;
    endfunction

    localparam logic signed [ANGULAR_W-1:0] NOISE_RST = noise_of(lfsr_step(LFSR_SEED));

endpackage

`default_nettype wire

>>> hdl/lidar_sector_obstacle_avoider_core.sv
// A scan-end word leaves on the command channel after passing the input register, the sector
// snapshot register and the command register.
// Throughput: one sample word per cycle when not stalled; a held non-final word never waits.
// Sample intake stalls only while a command word is held by cmd_stall and the snapshot is full.
// Reset: sectors empty, registers at their defaults, noise LFSR at its seed; no clearing pass.
`default_nettype none

module lidar_sector_obstacle_avoider_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // sample channel
    input  wire logic                                  sample_valid,
    output logic                                       sample_stall,
    input  wire logic [lsoa_pkg::RANGE_W-1:0]          range_mm,
    input  wire logic                                  sample_bad,
    input  wire logic [lsoa_pkg::ANGLE_W-1:0]          angle_deg,
    input  wire logic                                  scan_end,
    // command channel
    output logic                                       cmd_valid,
    input  wire logic                                  cmd_stall,
    output logic [lsoa_pkg::SPEED_W-1:0]               linear_mm_s,
    output logic signed [lsoa_pkg::ANGULAR_W-1:0]      angular_mrad_s,
    output logic                                       avoiding,
    output logic [lsoa_pkg::RANGE_W-1:0]               front_min_mm,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [lsoa_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [lsoa_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lsoa_pkg::APB_DATA_W-1:0]            prdata,
    output logic                                       pready
);

    // Configuration registers
    logic [lsoa_pkg::RANGE_W-1:0] obstacle_reg;
    logic [lsoa_pkg::RANGE_W-1:0] creep_limit_reg;
    logic [lsoa_pkg::RANGE_W-1:0] range_floor_reg;
    logic [lsoa_pkg::RANGE_W-1:0] range_ceiling_reg;
    logic [lsoa_pkg::SPEED_W-1:0] cruise_reg;
    logic [lsoa_pkg::SPEED_W-1:0] creep_reg;
    logic [lsoa_pkg::TURN_W-1:0]  turn_reg;

    logic                          cfg_write;
    logic [lsoa_pkg::REG_IDX_W-1:0] cfg_idx;

    // Input register
    logic                          in_valid_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  in_range_reg;
    logic                          in_bad_reg;
    logic [lsoa_pkg::ANGLE_W-1:0]  in_angle_reg;
    logic                          in_end_reg;

    // Sector state
    logic [lsoa_pkg::RANGE_W-1:0]  sector_min_reg  [lsoa_pkg::SECTOR_COUNT];
    logic [lsoa_pkg::SECTOR_COUNT-1:0] sector_seen_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  sector_min_next [lsoa_pkg::SECTOR_COUNT];
    logic [lsoa_pkg::SECTOR_COUNT-1:0] sector_seen_next;
    logic [lsoa_pkg::RANGE_W-1:0]  sector_rd       [lsoa_pkg::SECTOR_COUNT];

    // Snapshot register of one finished scan
    logic                          snap_valid_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  snap_front_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  snap_fleft_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  snap_fright_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  snap_left_reg;
    logic [lsoa_pkg::RANGE_W-1:0]  snap_right_reg;

    // Noise generator
    logic [lsoa_pkg::LFSR_W-1:0]         lfsr_reg;
    logic signed [lsoa_pkg::ANGULAR_W-1:0] noise_reg;

    // Command register
    logic                                 out_valid_reg;
    logic [lsoa_pkg::SPEED_W-1:0]         out_linear_reg;
    logic signed [lsoa_pkg::ANGULAR_W-1:0] out_angular_reg;
    logic                                 out_avoid_reg;
    logic [lsoa_pkg::RANGE_W-1:0]         out_front_reg;

    // Flow control
    logic sample_take;
    logic out_free;
    logic snap_move;
    logic snap_free;
    logic in_move;
    logic scan_done;

    // Per-sample decode
    logic                           range_ok;
    logic [lsoa_pkg::SECTOR_W-1:0]  sector_code;

    // Decision
    logic [lsoa_pkg::RANGE_W-1:0]          left_clear;
    logic [lsoa_pkg::RANGE_W-1:0]          right_clear;
    logic                                  avoid_now;
    logic [lsoa_pkg::SPEED_W-1:0]          linear_now;
    logic signed [lsoa_pkg::ANGULAR_W-1:0] turn_pos;
    logic signed [lsoa_pkg::ANGULAR_W-1:0] angular_now;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[lsoa_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_reg      <= lsoa_pkg::OBSTACLE_RST;
            creep_limit_reg   <= lsoa_pkg::CREEP_LIMIT_RST;
            range_floor_reg   <= lsoa_pkg::RANGE_FLOOR_RST;
            range_ceiling_reg <= lsoa_pkg::RANGE_CEILING_RST;
            cruise_reg        <= lsoa_pkg::CRUISE_RST;
            creep_reg         <= lsoa_pkg::CREEP_RST;
            turn_reg          <= lsoa_pkg::TURN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                lsoa_pkg::REG_OBSTACLE:      obstacle_reg      <= pwdata[lsoa_pkg::RANGE_W-1:0];
                lsoa_pkg::REG_CREEP_LIMIT:   creep_limit_reg   <= pwdata[lsoa_pkg::RANGE_W-1:0];
                lsoa_pkg::REG_RANGE_FLOOR:   range_floor_reg   <= pwdata[lsoa_pkg::RANGE_W-1:0];
                lsoa_pkg::REG_RANGE_CEILING: range_ceiling_reg <= pwdata[lsoa_pkg::RANGE_W-1:0];
                lsoa_pkg::REG_CRUISE:        cruise_reg        <= pwdata[lsoa_pkg::SPEED_W-1:0];
                lsoa_pkg::REG_CREEP:         creep_reg         <= pwdata[lsoa_pkg::SPEED_W-1:0];
                lsoa_pkg::REG_TURN:          turn_reg          <= pwdata[lsoa_pkg::TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            lsoa_pkg::REG_OBSTACLE:      prdata = 32'(obstacle_reg);
            lsoa_pkg::REG_CREEP_LIMIT:   prdata = 32'(creep_limit_reg);
            lsoa_pkg::REG_RANGE_FLOOR:   prdata = 32'(range_floor_reg);
            lsoa_pkg::REG_RANGE_CEILING: prdata = 32'(range_ceiling_reg);
            lsoa_pkg::REG_CRUISE:        prdata = 32'(cruise_reg);
            lsoa_pkg::REG_CREEP:         prdata = 32'(creep_reg);
            lsoa_pkg::REG_TURN:          prdata = 32'(turn_reg);
            default:                     prdata = '0;
        endcase
    end

    // Advance each stage when the stage after it has room
    assign out_free     = !out_valid_reg || !cmd_stall;
    assign snap_move    = snap_valid_reg && out_free;
    assign snap_free    = !snap_valid_reg || out_free;
    assign in_move      = in_valid_reg && (!in_end_reg || snap_free);
    assign scan_done    = in_move && in_end_reg;
    assign sample_stall = in_valid_reg && !in_move;
    assign sample_take  = sample_valid && !sample_stall;

    // Hold the accepted sample word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample_take)
            in_valid_reg <= 1'b1;
        else if (in_move)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            in_range_reg <= range_mm;
            in_bad_reg   <= sample_bad;
            in_angle_reg <= angle_deg;
            in_end_reg   <= scan_end;
        end
    end

    // Fold the sample into its sector minimum
    assign range_ok    = !in_bad_reg && (in_range_reg > range_floor_reg)
                         && (in_range_reg < range_ceiling_reg);
    assign sector_code = lsoa_pkg::sector_of(in_angle_reg);

    always_comb
    begin
        for (int i = 0; i < lsoa_pkg::SECTOR_COUNT; i++)
        begin
            logic hit;
            hit = in_valid_reg && range_ok && (sector_code == lsoa_pkg::SECTOR_W'(i));
            if (hit && (!sector_seen_reg[i] || (in_range_reg < sector_min_reg[i])))
                sector_min_next[i] = in_range_reg;
            else
                sector_min_next[i] = sector_min_reg[i];
            sector_seen_next[i] = sector_seen_reg[i] || hit;
            sector_rd[i] = sector_seen_next[i] ? sector_min_next[i] : lsoa_pkg::EMPTY_MM;
        end
    end

    // Clear the sectors at the end of a scan, else keep the folded values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sector_seen_reg <= '0;
        else if (scan_done)
            sector_seen_reg <= '0;
        else if (in_move)
            sector_seen_reg <= sector_seen_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            for (int i = 0; i < lsoa_pkg::SECTOR_COUNT; i++)
                sector_min_reg[i] <= sector_min_next[i];
        end
    end

    // Capture the finished scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (scan_done)
            snap_valid_reg <= 1'b1;
        else if (snap_move)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (scan_done)
        begin
            snap_front_reg  <= sector_rd[lsoa_pkg::SEC_FRONT];
            snap_fleft_reg  <= sector_rd[lsoa_pkg::SEC_FLEFT];
            snap_fright_reg <= sector_rd[lsoa_pkg::SEC_FRIGHT];
            snap_left_reg   <= sector_rd[lsoa_pkg::SEC_LEFT];
            snap_right_reg  <= sector_rd[lsoa_pkg::SEC_RIGHT];
        end
    end

    // Pick the mode and the velocity command
    assign left_clear  = (snap_fleft_reg < snap_left_reg) ? snap_fleft_reg : snap_left_reg;
    assign right_clear = (snap_fright_reg < snap_right_reg) ? snap_fright_reg : snap_right_reg;
    assign avoid_now   = snap_front_reg < obstacle_reg;
    assign turn_pos    = $signed({1'b0, turn_reg});

    always_comb
    begin
        if (avoid_now)
        begin
            linear_now  = (snap_front_reg > creep_limit_reg) ? creep_reg : '0;
            angular_now = (left_clear > right_clear) ? turn_pos : -turn_pos;
        end
        else
        begin
            linear_now  = cruise_reg;
            angular_now = noise_reg;
        end
    end

    // Step the noise source on each explore decision; keep the next noise value ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg  <= lsoa_pkg::LFSR_SEED;
            noise_reg <= lsoa_pkg::NOISE_RST;
        end
        else if (snap_move && !avoid_now)
        begin
            lfsr_reg  <= lsoa_pkg::lfsr_step(lfsr_reg);
            noise_reg <= lsoa_pkg::noise_of(lsoa_pkg::lfsr_step(lsoa_pkg::lfsr_step(lfsr_reg)));
        end
    end

    // Hold the command word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_move)
            out_valid_reg <= 1'b1;
        else if (!cmd_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_move)
        begin
            out_linear_reg  <= linear_now;
            out_angular_reg <= angular_now;
            out_avoid_reg   <= avoid_now;
            out_front_reg   <= snap_front_reg;
        end
    end

    assign cmd_valid      = out_valid_reg;
    assign linear_mm_s    = out_linear_reg;
    assign angular_mrad_s = out_angular_reg;
    assign avoiding       = out_avoid_reg;
    assign front_min_mm   = out_front_reg;

endmodule

`default_nettype wire

>>> hdl/lsoa_checker.sv
// Port-level checker for the lidar sector obstacle avoider and its bind.
`default_nettype none
`include "lidar_sector_obstacle_avoider_core_defines.svh"

module lsoa_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  sample_valid,
    input wire logic                                  sample_stall,
    input wire logic                                  scan_end,
    input wire logic                                  cmd_valid,
    input wire logic                                  cmd_stall,
    input wire logic [lsoa_pkg::SPEED_W-1:0]          linear_mm_s,
    input wire logic signed [lsoa_pkg::ANGULAR_W-1:0] angular_mrad_s,
    input wire logic                                  avoiding,
    input wire logic [lsoa_pkg::RANGE_W-1:0]          front_min_mm
);

    // A held command word keeps its contents
    `LSOA_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(linear_mm_s) && $stable(angular_mrad_s) && $stable(avoiding) && $stable(front_min_mm), "command word changed while stalled")

    // Samples are never refused while the command side is empty
    `LSOA_ASSERT_NOW(a_no_idle_stall, !cmd_valid, !sample_stall, "sample stalled with no command pending")

    // A scan end brings a valid command word once it has passed the pipeline
    `LSOA_ASSERT_LATER3(a_scan_cmd, sample_valid && !sample_stall && scan_end, cmd_valid, "no command after scan end")

    // Explore noise stays even and within its span
    `LSOA_ASSERT_NOW(a_noise_span, cmd_valid && !avoiding, (angular_mrad_s >= -13'sd100) && (angular_mrad_s <= 13'sd98) && !angular_mrad_s[0], "explore turn noise out of span")

endmodule

bind lidar_sector_obstacle_avoider_core lsoa_checker u_lsoa_checker (.*);

`default_nettype wire

>>> sim/lidar_sector_obstacle_avoider_core_tb.sv
// Self-checking testbench for the lidar sector obstacle avoider core.
module lidar_sector_obstacle_avoider_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam logic [lsoa_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [lsoa_pkg::RANGE_W-1:0] range;
        logic                         bad;
        logic [lsoa_pkg::ANGLE_W-1:0] angle;
        logic                         last;
        int                           gap;
    } sample_word_t;

    typedef struct {
        logic [lsoa_pkg::SPEED_W-1:0]          linear;
        logic signed [lsoa_pkg::ANGULAR_W-1:0] angular;
        logic                                  avoid;
        logic [lsoa_pkg::RANGE_W-1:0]          front;
    } motion_cmd_t;

    // DUT ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic [lsoa_pkg::RANGE_W-1:0] range_mm = '0;
    logic sample_bad = 1'b0;
    logic [lsoa_pkg::ANGLE_W-1:0] angle_deg = '0;
    logic scan_end = 1'b0;
    logic cmd_valid;
    logic cmd_stall = 1'b0;
    logic [lsoa_pkg::SPEED_W-1:0] linear_mm_s;
    logic signed [lsoa_pkg::ANGULAR_W-1:0] angular_mrad_s;
    logic avoiding;
    logic [lsoa_pkg::RANGE_W-1:0] front_min_mm;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [lsoa_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [lsoa_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [lsoa_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    // Register copies used by the predictor
    logic [lsoa_pkg::RANGE_W-1:0] obstacle_lim = lsoa_pkg::OBSTACLE_RST;
    logic [lsoa_pkg::RANGE_W-1:0] creep_lim = lsoa_pkg::CREEP_LIMIT_RST;
    logic [lsoa_pkg::RANGE_W-1:0] floor_lim = lsoa_pkg::RANGE_FLOOR_RST;
    logic [lsoa_pkg::RANGE_W-1:0] ceil_lim = lsoa_pkg::RANGE_CEILING_RST;
    logic [lsoa_pkg::SPEED_W-1:0] cruise_spd = lsoa_pkg::CRUISE_RST;
    logic [lsoa_pkg::SPEED_W-1:0] creep_spd = lsoa_pkg::CREEP_RST;
    logic [lsoa_pkg::TURN_W-1:0]  turn_rate = lsoa_pkg::TURN_RST;

    // Predicted sector state
    logic [lsoa_pkg::RANGE_W-1:0] sec_min [lsoa_pkg::SECTOR_COUNT];
    logic                         sec_seen [lsoa_pkg::SECTOR_COUNT];
    logic [lsoa_pkg::LFSR_W-1:0]  noise_reg = lsoa_pkg::LFSR_SEED;

    sample_word_t sample_q[$];
    motion_cmd_t  cmd_due_q[$];
    sample_word_t next_word;
    motion_cmd_t  got_cmd;

    int  words_queued = 0;
    int  words_taken = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  gap_count = 0;
    int  cmd_wait = 0;
    logic sample_fire = 1'b0;
    logic cmd_fire = 1'b0;
    logic send_eager = 1'b0;
    logic recv_eager = 1'b0;
    logic cmd_hold_off = 1'b0;
    logic hold_off_arm = 1'b0;

    lidar_sector_obstacle_avoider_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .range_mm(range_mm), .sample_bad(sample_bad),
        .angle_deg(angle_deg), .scan_end(scan_end),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .linear_mm_s(linear_mm_s), .angular_mrad_s(angular_mrad_s),
        .avoiding(avoiding), .front_min_mm(front_min_mm),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < lsoa_pkg::SECTOR_COUNT; i++)
        begin
            sec_min[i] = '1;
            sec_seen[i] = 1'b0;
        end
    end

    // Sector that a bearing falls in, or none
    function automatic logic [lsoa_pkg::SECTOR_W-1:0] bearing_sector(
        input logic [lsoa_pkg::ANGLE_W-1:0] a);
        if (a <= 15 || (a >= 345 && a <= 359)) return lsoa_pkg::SEC_FRONT;
        if (a >= 30 && a <= 60) return lsoa_pkg::SEC_FLEFT;
        if (a >= 300 && a <= 330) return lsoa_pkg::SEC_FRIGHT;
        if (a >= 80 && a <= 100) return lsoa_pkg::SEC_LEFT;
        if (a >= 260 && a <= 280) return lsoa_pkg::SEC_RIGHT;
        if (a >= 170 && a <= 190) return lsoa_pkg::SEC_BACK;
        return lsoa_pkg::SEC_NONE;
    endfunction

    function automatic logic [lsoa_pkg::RANGE_W-1:0] sector_reading(
        input logic [lsoa_pkg::SECTOR_W-1:0] s);
        return sec_seen[s] ? sec_min[s] : lsoa_pkg::EMPTY_MM;
    endfunction

    // Fold one accepted sample into the sectors; on scan end, predict the command
    task automatic fold_sample(input sample_word_t w);
        logic [lsoa_pkg::SECTOR_W-1:0] s;
        logic [lsoa_pkg::RANGE_W-1:0] lc;
        logic [lsoa_pkg::RANGE_W-1:0] rc;
        motion_cmd_t c;
        int ang;
        s = bearing_sector(w.angle);
        if (s != lsoa_pkg::SEC_NONE && !w.bad && w.range > floor_lim && w.range < ceil_lim)
        begin
            if (!sec_seen[s] || w.range < sec_min[s])
                sec_min[s] = w.range;
            sec_seen[s] = 1'b1;
        end
        if (w.last)
        begin
            c.front = sector_reading(lsoa_pkg::SEC_FRONT);
            c.avoid = c.front < obstacle_lim;
            if (c.avoid)
            begin
                lc = sector_reading(lsoa_pkg::SEC_FLEFT) < sector_reading(lsoa_pkg::SEC_LEFT) ?
                     sector_reading(lsoa_pkg::SEC_FLEFT) : sector_reading(lsoa_pkg::SEC_LEFT);
                rc = sector_reading(lsoa_pkg::SEC_FRIGHT) < sector_reading(lsoa_pkg::SEC_RIGHT) ?
                     sector_reading(lsoa_pkg::SEC_FRIGHT) : sector_reading(lsoa_pkg::SEC_RIGHT);
                c.linear = c.front > creep_lim ? creep_spd : '0;
                ang = lc > rc ? int'(turn_rate) : -int'(turn_rate);
            end
            else
            begin
                noise_reg = {noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5],
                             noise_reg[lsoa_pkg::LFSR_W-1:1]};
                c.linear = cruise_spd;
                ang = 2 * (int'(noise_reg % 16'd100) - 50);
            end
            c.angular = ang[lsoa_pkg::ANGULAR_W-1:0];
            cmd_due_q.push_back(c);
            for (int i = 0; i < lsoa_pkg::SECTOR_COUNT; i++)
            begin
                sec_min[i] = '1;
                sec_seen[i] = 1'b0;
            end
        end
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Compare one command word against the oldest prediction
    task automatic check_command(input motion_cmd_t got);
        motion_cmd_t want;
        if (cmd_due_q.size() == 0)
        begin
            report_error($sformatf("command word with none expected: lin=%0d ang=%0d av=%0d fr=%0d",
                                   got.linear, got.angular, got.avoid, got.front));
        end
        else
        begin
            want = cmd_due_q.pop_front();
            if (got.linear !== want.linear)
                report_error($sformatf("linear_mm_s: expected %0d, got %0d",
                                       want.linear, got.linear));
            if (got.angular !== want.angular)
                report_error($sformatf("angular_mrad_s: expected %0d, got %0d",
                                       want.angular, got.angular));
            if (got.avoid !== want.avoid)
                report_error($sformatf("avoiding: expected %0d, got %0d",
                                       want.avoid, got.avoid));
            if (got.front !== want.front)
                report_error($sformatf("front_min_mm: expected %0d, got %0d",
                                       want.front, got.front));
        end
    endtask

    // Monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("lidar_sector_obstacle_avoider_core_tb NOT OK");
            $finish;
        end
        else
        begin
            sample_fire = rst_n && sample_valid && !sample_stall;
            cmd_fire = rst_n && cmd_valid && !cmd_stall;
            if (cmd_fire)
            begin
                got_cmd.linear = linear_mm_s;
                got_cmd.angular = angular_mrad_s;
                got_cmd.avoid = avoiding;
                got_cmd.front = front_min_mm;
                check_command(got_cmd);
            end
            if (sample_fire)
            begin
                next_word.range = range_mm;
                next_word.bad = sample_bad;
                next_word.angle = angle_deg;
                next_word.last = scan_end;
                next_word.gap = 0;
                fold_sample(next_word);
                words_taken++;
            end
        end
    end

    // Sample driver: offer the next word once the slot is free and its gap has passed
    always @(negedge clk)
    begin
        if (!sample_valid || sample_fire)
        begin
            if (rst_n && sample_q.size() != 0 && gap_count >= sample_q[0].gap)
            begin
                next_word = sample_q.pop_front();
                range_mm <= next_word.range;
                sample_bad <= next_word.bad;
                angle_deg <= next_word.angle;
                scan_end <= next_word.last;
                sample_valid <= 1'b1;
                gap_count = 0;
            end
            else
            begin
                sample_valid <= 1'b0;
                if (sample_q.size() != 0)
                    gap_count++;
            end
        end
    end

    // Command receiver: random stall per word, plus the long hold-off
    always @(negedge clk)
    begin
        if (cmd_fire)
            cmd_wait = recv_eager ? 0 : $urandom_range(0, 4);
        if (cmd_hold_off || cmd_wait != 0)
        begin
            cmd_stall <= 1'b1;
            if (cmd_wait != 0)
                cmd_wait--;
        end
        else
            cmd_stall <= 1'b0;
    end

    // Long receiver hold-off so the pipeline fills and the sample side stalls
    initial
    begin
        wait (hold_off_arm);
        repeat (30) @(posedge clk);
        cmd_hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        cmd_hold_off <= 1'b0;
    end

    task automatic queue_sample(input int range, input logic bad, input int angle,
                                input logic last);
        sample_word_t w;
        w.range = range[lsoa_pkg::RANGE_W-1:0];
        w.bad = bad;
        w.angle = angle[lsoa_pkg::ANGLE_W-1:0];
        w.last = last;
        w.gap = send_eager ? 0 : $urandom_range(0, 4);
        sample_q.push_back(w);
        words_queued++;
    endtask

    task automatic write_register(input logic [lsoa_pkg::REG_IDX_W-1:0] idx,
                                  input logic [lsoa_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            lsoa_pkg::REG_OBSTACLE:      obstacle_lim = data[lsoa_pkg::RANGE_W-1:0];
            lsoa_pkg::REG_CREEP_LIMIT:   creep_lim = data[lsoa_pkg::RANGE_W-1:0];
            lsoa_pkg::REG_RANGE_FLOOR:   floor_lim = data[lsoa_pkg::RANGE_W-1:0];
            lsoa_pkg::REG_RANGE_CEILING: ceil_lim = data[lsoa_pkg::RANGE_W-1:0];
            lsoa_pkg::REG_CRUISE:        cruise_spd = data[lsoa_pkg::SPEED_W-1:0];
            lsoa_pkg::REG_CREEP:         creep_spd = data[lsoa_pkg::SPEED_W-1:0];
            lsoa_pkg::REG_TURN:          turn_rate = data[lsoa_pkg::TURN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic write_all(input int obst, input int creep_l, input int flr, input int ceil,
                             input int cruise, input int creep, input int turn,
                             input logic junk);
        logic [lsoa_pkg::APB_DATA_W-1:0] hi;
        hi = junk ? $urandom() : '0;
        write_register(lsoa_pkg::REG_OBSTACLE, (hi << lsoa_pkg::RANGE_W) | obst);
        write_register(lsoa_pkg::REG_CREEP_LIMIT, (hi << lsoa_pkg::RANGE_W) | creep_l);
        write_register(lsoa_pkg::REG_RANGE_FLOOR, (hi << lsoa_pkg::RANGE_W) | flr);
        write_register(lsoa_pkg::REG_RANGE_CEILING, (hi << lsoa_pkg::RANGE_W) | ceil);
        write_register(lsoa_pkg::REG_CRUISE, (hi << lsoa_pkg::SPEED_W) | cruise);
        write_register(lsoa_pkg::REG_CREEP, (hi << lsoa_pkg::SPEED_W) | creep);
        write_register(lsoa_pkg::REG_TURN, (hi << lsoa_pkg::TURN_W) | turn);
    endtask

    // Hold until every queued word is taken and every command is out, then drain
    task automatic wait_idle();
        @(negedge clk);
        while (words_taken != words_queued || cmd_due_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int range_near(input int centre);
        int v;
        v = centre + int'($urandom_range(0, 4)) - 2;
        return v < 0 ? 0 : (v > 65535 ? 65535 : v);
    endfunction

    // Ranges biased toward the thresholds that steer the decision
    function automatic int pick_range();
        int hi;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535);
            1: return range_near(floor_lim);
            2: return range_near(ceil_lim);
            3: return range_near(obstacle_lim);
            4: return range_near(creep_lim);
            5, 6:
            begin
                hi = int'(obstacle_lim) + 200;
                return (hi > floor_lim) ? $urandom_range(floor_lim, hi) : $urandom_range(0, 65535);
            end
            default:
                return (ceil_lim > floor_lim) ? $urandom_range(floor_lim, ceil_lim)
                                              : $urandom_range(0, 65535);
        endcase
    endfunction

    // Whole scans with random content, now and then a one-sample scan
    task automatic queue_random_scans(input int count);
        int n;
        int len;
        int ang;
        n = 0;
        @(posedge clk);
        while (n < count)
        begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(4, 40);
            for (int k = 0; k < len; k++)
            begin
                ang = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
                                                  : $urandom_range(0, 359);
                queue_sample(pick_range(), $urandom_range(0, 9) == 0, ang, k == len - 1);
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: range limits, bad and out-of-range bearings, both modes and turn sides
        queue_sample(121, 1'b0, 0, 1'b0);
        queue_sample(120, 1'b0, 359, 1'b0);
        queue_sample(3500, 1'b0, 15, 1'b0);
        queue_sample(200, 1'b1, 345, 1'b0);
        queue_sample(200, 1'b0, 360, 1'b0);
        queue_sample(0, 1'b0, 511, 1'b1);
        queue_sample(400, 1'b0, 0, 1'b0);
        queue_sample(600, 1'b0, 30, 1'b0);
        queue_sample(1000, 1'b0, 280, 1'b0);
        queue_sample(3499, 1'b0, 100, 1'b0);
        queue_sample(700, 1'b0, 330, 1'b0);
        queue_sample(800, 1'b0, 190, 1'b1);
        queue_sample(499, 1'b0, 345, 1'b0);
        queue_sample(200, 1'b0, 16, 1'b0);
        queue_sample(2000, 1'b0, 60, 1'b0);
        queue_sample(1500, 1'b0, 80, 1'b0);
        queue_sample(200, 1'b0, 300, 1'b0);
        queue_sample(900, 1'b0, 260, 1'b0);
        queue_sample(3499, 1'b0, 15, 1'b1);
        queue_sample(65535, 1'b1, 0, 1'b1);
        queue_sample(500, 1'b0, 0, 1'b1);
        queue_sample(3000, 1'b0, 350, 1'b0);
        queue_sample(300, 1'b0, 5, 1'b0);
        queue_sample(800, 1'b0, 10, 1'b0);
        queue_sample(65535, 1'b0, 100, 1'b1);
        wait_idle();

        // Defaults, with the long receiver hold-off
        hold_off_arm = 1'b1;
        queue_random_scans(300);
        wait_idle();

        // Upper extremes, no idling on either side
        write_all(65535, 0, 0, 65535, 2000, 2000, 4000, 1'b0);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_eager = 1'b1;
        recv_eager = 1'b1;
        queue_random_scans(300);
        wait_idle();

        // Lower extremes: nothing is valid and the block never avoids
        send_eager = 1'b0;
        recv_eager = 1'b0;
        write_all(0, 65535, 65535, 0, 0, 0, 0, 1'b0);
        queue_random_scans(200);
        wait_idle();

        // Random settings with junk above each register's width
        for (int p = 0; p < 3; p++)
        begin
            send_eager = (p == 1);
            write_all($urandom_range(0, 4000), $urandom_range(0, 2000),
                      $urandom_range(0, 500), $urandom_range(1000, 65535),
                      $urandom_range(0, 2000), $urandom_range(0, 2000),
                      $urandom_range(0, 4000), 1'b1);
            queue_random_scans(250);
            wait_idle();
        end

        if (mismatches == 0)
            $display("lidar_sector_obstacle_avoider_core_tb OK");
        else
            $display("lidar_sector_obstacle_avoider_core_tb NOT OK");
        $finish;
    end

endmodule
